>>> sv/ctp_pkg.sv
// ctp_pkg: shared sizes, operation and status codes, and payload structs
// for the csr_matrix_transpose block; no dependencies
`timescale 1ns / 1ps

package ctp_pkg;

	// store sizes
	localparam int MAX_NONZEROS = 4096;
	localparam int MAX_DIM      = 1024;
	localparam int NZ_AW        = $clog2(MAX_NONZEROS);
	localparam int DIM_AW       = $clog2(MAX_DIM);
	localparam int CNT_W        = $clog2(MAX_NONZEROS + 1);
	localparam int COLS_W       = $clog2(MAX_DIM + 1);

	// operation codes
	localparam logic [2:0] OP_PUSH       = 3'd0;
	localparam logic [2:0] OP_END_ROW    = 3'd1;
	localparam logic [2:0] OP_FINISH     = 3'd2;
	localparam logic [2:0] OP_READ_ENTRY = 3'd3;
	localparam logic [2:0] OP_READ_PTR   = 3'd4;

	// status codes
	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_FULL     = 3'd1;
	localparam logic [2:0] STAT_COLUMN   = 3'd2;
	localparam logic [2:0] STAT_INDEX    = 3'd3;
	localparam logic [2:0] STAT_NOT_DONE = 3'd4;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [9:0]  col_index;
		logic [63:0] entry_value;
		logic [12:0] read_index;
	} ctp_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [9:0]  out_index;
		logic [63:0] out_value;
		logic [12:0] out_pointer;
	} ctp_rsp_t;

	// one loaded nonzero
	typedef struct packed {
		logic [DIM_AW-1:0] col;
		logic [DIM_AW-1:0] row;
		logic [63:0]       val;
	} src_entry_t;

	// one transposed nonzero
	typedef struct packed {
		logic [DIM_AW-1:0] row;
		logic [63:0]       val;
	} tr_entry_t;

endpackage

>>> sv/csr_matrix_transpose.sv
// csr_matrix_transpose: CSR transpose by counting sort around three memories
// (column counts, loaded entries, transposed entries); depends on ctp_pkg
`timescale 1ns / 1ps

// Usage:
// Requests come in on req (valid/ready), one op per transfer: push nonzero,
// end row, finish, read entry, read pointer. Every request gives exactly one
// response on rsp (valid/ready), in request order.
// cfg_we/cfg_wdata write the column count; write it only while idle.
// A response goes through the result stage, which takes the memory read,
// and then the output register.
// Throughput: pushes, end rows and reads take one request per cycle while rsp_ready is high.
// A finish that starts a pass holds req_ready low through the prefix
// walk over the count memory (one count per cycle) and then the scatter,
// one entry per cycle through the entry memory, count memory and
// transposed memory.
// Reset: a clearing pass zeroes the count memory with req_ready low.
// A push or end row after a finish first runs the same clearing pass,
// then the op is taken.
// Stall: when rsp_ready is low the output register and one more stage
// hold results; once both are full req_ready drops.
module csr_matrix_transpose
	import ctp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  ctp_req_t    req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output ctp_rsp_t    rsp,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_RUN,
		S_PREFIX,
		S_SCATTER,
		S_FIN_OUT
	} state_t;

	state_t state_q;

	logic [10:0]       colcnt_q;
	logic [COLS_W-1:0] row_q;
	logic [CNT_W-1:0]  entry_q;
	logic              fin_q;

	logic [DIM_AW-1:0] clr_q;
	logic [DIM_AW:0]   pf_rd_q;
	logic              pf_wv_q;
	logic [DIM_AW-1:0] pf_wa_q;
	logic [CNT_W-1:0]  acc_q;

	logic [CNT_W-1:0]  sc_rd_q;
	logic              sc_v_s1;
	logic              sc_v_s2;
	logic [DIM_AW-1:0] sc_col_s2;
	tr_entry_t         sc_ent_s2;

	logic              inc_v_q;
	logic [DIM_AW-1:0] inc_a_q;

	// count memory and its port
	logic [CNT_W-1:0]  cnt_mem [MAX_DIM];
	logic [CNT_W-1:0]  cnt_rdata_q;
	logic              cnt_hit_q;
	logic [CNT_W-1:0]  cnt_fwd_q;
	logic [CNT_W-1:0]  cnt_old;
	logic              cnt_re;
	logic [DIM_AW-1:0] cnt_ra;
	logic              cnt_we;
	logic [DIM_AW-1:0] cnt_wa;
	logic [CNT_W-1:0]  cnt_wd;

	src_entry_t        src_mem [MAX_NONZEROS];
	src_entry_t        src_rdata_q;
	logic              src_we;
	logic              sc_re;

	tr_entry_t         tr_mem [MAX_NONZEROS];
	tr_entry_t         tr_rdata_q;
	logic              tr_re;

	// result stage and output register
	logic              rsp_v_s1;
	logic [2:0]        stat_s1;
	logic [CNT_W-1:0]  ptr_s1;
	logic              sel_tr_s1;
	logic              sel_cnt_s1;
	logic              rsp_v_q;
	ctp_rsp_t          rsp_q;
	ctp_rsp_t          s1_result;

	logic [COLS_W-1:0] eff_cols;
	logic              is_load;
	logic              out_adv;
	logic              s1_free;
	logic              acc;
	logic              push_full;
	logic              col_bad;
	logic              push_ok;
	logic              push_inc;
	logic              s1_load;
	logic [2:0]        ld_stat;
	logic [CNT_W-1:0]  ld_ptr;
	logic              ld_sel_tr;
	logic              ld_sel_cnt;
	logic              dec_fin_go;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colcnt_q <= 11'(MAX_DIM);
		end else if (cfg_we) begin
			colcnt_q <= cfg_wdata;
		end
	end

	// handshake and push checks
	assign eff_cols  = (colcnt_q > 11'(MAX_DIM)) ? COLS_W'(MAX_DIM) : COLS_W'(colcnt_q);
	assign is_load   = (req.opcode == OP_PUSH) || (req.opcode == OP_END_ROW);
	assign out_adv   = !rsp_v_q || rsp_ready;
	assign s1_free   = !rsp_v_s1 || out_adv;
	assign req_ready = (state_q == S_RUN) && s1_free && !(req_valid && is_load && fin_q);
	assign acc       = req_valid && req_ready;
	assign push_full = (entry_q >= CNT_W'(MAX_NONZEROS)) || (row_q >= COLS_W'(MAX_DIM));
	assign col_bad   = COLS_W'(req.col_index) >= eff_cols;
	assign push_ok   = !push_full && !col_bad;
	assign push_inc  = push_ok && (req.col_index != 10'(MAX_DIM - 1));

	// request decode into the result stage
	always_comb begin
		ld_stat    = STAT_OK;
		ld_ptr     = '0;
		ld_sel_tr  = 1'b0;
		ld_sel_cnt = 1'b0;
		dec_fin_go = 1'b0;
		if (state_q == S_FIN_OUT) begin
			ld_ptr = entry_q;
		end else begin
			unique case (req.opcode)
				OP_PUSH: begin
					if (push_full)
						ld_stat = STAT_FULL;
					else if (col_bad)
						ld_stat = STAT_COLUMN;
				end
				OP_END_ROW: begin
					if (row_q >= COLS_W'(MAX_DIM))
						ld_stat = STAT_FULL;
				end
				OP_FINISH: begin
					ld_ptr     = entry_q;
					dec_fin_go = !fin_q;
				end
				OP_READ_ENTRY: begin
					if (!fin_q)
						ld_stat = STAT_NOT_DONE;
					else if (req.read_index >= entry_q)
						ld_stat = STAT_INDEX;
					else
						ld_sel_tr = 1'b1;
				end
				OP_READ_PTR: begin
					if (!fin_q)
						ld_stat = STAT_NOT_DONE;
					else if (req.read_index > 13'(eff_cols))
						ld_stat = STAT_INDEX;
					else if (req.read_index != 13'd0)
						ld_sel_cnt = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign s1_load = (acc && !dec_fin_go) || (state_q == S_FIN_OUT);

	// count port: forwarded old value, read and write selection
	assign cnt_old = cnt_hit_q ? cnt_fwd_q : cnt_rdata_q;

	always_comb begin
		cnt_re = 1'b0;
		cnt_ra = '0;
		unique case (state_q)
			S_RUN: begin
				if (acc && (req.opcode == OP_PUSH) && push_inc) begin
					cnt_re = 1'b1;
					cnt_ra = req.col_index + 10'd1;
				end else if (acc && ld_sel_cnt) begin
					cnt_re = 1'b1;
					cnt_ra = DIM_AW'(req.read_index - 13'd1);
				end
			end
			S_PREFIX: begin
				cnt_re = !pf_rd_q[DIM_AW];
				cnt_ra = pf_rd_q[DIM_AW-1:0];
			end
			S_SCATTER: begin
				cnt_re = sc_v_s1;
				cnt_ra = src_rdata_q.col;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		cnt_we = 1'b0;
		cnt_wa = '0;
		cnt_wd = '0;
		priority if (inc_v_q) begin
			cnt_we = 1'b1;
			cnt_wa = inc_a_q;
			cnt_wd = cnt_old + CNT_W'(1);
		end else if (state_q == S_CLEAR) begin
			cnt_we = 1'b1;
			cnt_wa = clr_q;
		end else if (state_q == S_PREFIX) begin
			cnt_we = pf_wv_q;
			cnt_wa = pf_wa_q;
			cnt_wd = cnt_old + acc_q;
		end else if (state_q == S_SCATTER) begin
			cnt_we = sc_v_s2;
			cnt_wa = sc_col_s2;
			cnt_wd = cnt_old + CNT_W'(1);
		end
	end

	// count memory, with same-edge write forwarding
	always_ff @(posedge clk) begin
		if (cnt_we)
			cnt_mem[cnt_wa] <= cnt_wd;
		if (cnt_re) begin
			cnt_rdata_q <= cnt_mem[cnt_ra];
			cnt_hit_q   <= cnt_we && (cnt_wa == cnt_ra);
			cnt_fwd_q   <= cnt_wd;
		end
	end

	// loaded entry memory
	assign src_we = acc && (req.opcode == OP_PUSH) && push_ok;
	assign sc_re  = (state_q == S_SCATTER) && (sc_rd_q < entry_q);

	always_ff @(posedge clk) begin
		if (src_we)
			src_mem[entry_q[NZ_AW-1:0]] <= '{col: req.col_index, row: row_q[DIM_AW-1:0],
				val: req.entry_value};
		if (sc_re)
			src_rdata_q <= src_mem[sc_rd_q[NZ_AW-1:0]];
	end

	// transposed entry memory
	assign tr_re = acc && ld_sel_tr;

	always_ff @(posedge clk) begin
		if (sc_v_s2)
			tr_mem[cnt_old[NZ_AW-1:0]] <= sc_ent_s2;
		if (tr_re)
			tr_rdata_q <= tr_mem[req.read_index[NZ_AW-1:0]];
	end

	// scatter pipeline payload
	always_ff @(posedge clk) begin
		sc_col_s2 <= src_rdata_q.col;
		sc_ent_s2 <= '{row: src_rdata_q.row, val: src_rdata_q.val};
	end

	// response assembled from the result stage
	always_comb begin
		s1_result.status      = stat_s1;
		s1_result.out_index   = sel_tr_s1 ? tr_rdata_q.row : '0;
		s1_result.out_value   = sel_tr_s1 ? tr_rdata_q.val : '0;
		s1_result.out_pointer = sel_cnt_s1 ? cnt_old : ptr_s1;
	end

	// sequencer, counters, result stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			row_q      <= '0;
			entry_q    <= '0;
			fin_q      <= 1'b0;
			clr_q      <= '0;
			pf_rd_q    <= '0;
			pf_wv_q    <= 1'b0;
			pf_wa_q    <= '0;
			acc_q      <= '0;
			sc_rd_q    <= '0;
			sc_v_s1    <= 1'b0;
			sc_v_s2    <= 1'b0;
			inc_v_q    <= 1'b0;
			inc_a_q    <= '0;
			rsp_v_s1   <= 1'b0;
			stat_s1    <= STAT_OK;
			ptr_s1     <= '0;
			sel_tr_s1  <= 1'b0;
			sel_cnt_s1 <= 1'b0;
			rsp_v_q    <= 1'b0;
			rsp_q      <= '0;
		end else begin
			inc_v_q <= 1'b0;
			sc_v_s1 <= sc_re;
			sc_v_s2 <= sc_v_s1;

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + DIM_AW'(1);
					if (clr_q == DIM_AW'(MAX_DIM - 1)) begin
						state_q <= S_RUN;
						row_q   <= '0;
						entry_q <= '0;
						fin_q   <= 1'b0;
					end
				end
				S_RUN: begin
					if (req_valid && is_load && fin_q) begin
						state_q <= S_CLEAR;
					end else if (acc) begin
						unique case (req.opcode)
							OP_PUSH: begin
								if (push_ok)
									entry_q <= entry_q + CNT_W'(1);
								inc_v_q <= push_inc;
								inc_a_q <= req.col_index + 10'd1;
							end
							OP_END_ROW: begin
								if (row_q < COLS_W'(MAX_DIM))
									row_q <= row_q + COLS_W'(1);
							end
							OP_FINISH: begin
								if (!fin_q) begin
									state_q <= S_PREFIX;
									pf_rd_q <= '0;
									pf_wv_q <= 1'b0;
									acc_q   <= '0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_PREFIX: begin
					if (cnt_re)
						pf_rd_q <= pf_rd_q + (DIM_AW+1)'(1);
					pf_wv_q <= cnt_re;
					pf_wa_q <= pf_rd_q[DIM_AW-1:0];
					if (pf_wv_q)
						acc_q <= cnt_wd;
					if (pf_rd_q[DIM_AW] && !pf_wv_q) begin
						state_q <= S_SCATTER;
						sc_rd_q <= '0;
					end
				end
				S_SCATTER: begin
					if (sc_re)
						sc_rd_q <= sc_rd_q + CNT_W'(1);
					if (!sc_re && !sc_v_s1 && !sc_v_s2) begin
						state_q <= S_FIN_OUT;
						fin_q   <= 1'b1;
					end
				end
				S_FIN_OUT: begin
					if (s1_free)
						state_q <= S_RUN;
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase

			// result stage
			if (s1_free) begin
				rsp_v_s1 <= s1_load;
				if (s1_load) begin
					stat_s1    <= ld_stat;
					ptr_s1     <= ld_ptr;
					sel_tr_s1  <= ld_sel_tr;
					sel_cnt_s1 <= ld_sel_cnt;
				end
			end

			// output register
			if (out_adv) begin
				rsp_v_q <= rsp_v_s1;
				if (rsp_v_s1)
					rsp_q <= s1_result;
			end
		end
	end

	assign rsp_valid = rsp_v_q;
	assign rsp       = rsp_q;

	// requests are taken only in the run state
	a_accept_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |-> (state_q == S_RUN))
		else $error("request transfer outside run state");

	// entry counter stays within the store
	a_entry_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_q <= CNT_W'(MAX_NONZEROS))
		else $error("entry counter beyond store size");

	// scatter position lies inside the loaded entries
	a_scatter_pos: assert property (@(posedge clk) disable iff (!arst_n)
		sc_v_s2 |-> (cnt_old < entry_q))
		else $error("scatter position beyond entry count");

	// finished flag rises only as the pass hands over its result
	a_fin_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fin_q) |-> (state_q == S_FIN_OUT))
		else $error("finished flag set outside end of pass");

endmodule
